/* design/pfr_pkg.sv */
`default_nettype none

package pfr_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REFRESH = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // Panel command bytes sent ahead of each page
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    localparam int CMD_SLOTS = 3;

endpackage

`default_nettype wire

/* design/page_framebuffer_refresh_top.sv */
`default_nettype none

// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------
// request   op, x, y, dot                           taken when start && !busy
// result    bus_byte, is_data, frame_done           strobe high for one cycle
//
// A draw or tick request is taken every cycle while busy is low; the result
// of a tick shows on the result ports in the cycle after it is taken (the
// store read is registered). A clear request, and reset itself, sweep the
// frame store one byte a cycle: busy stays high while zeros are written.
// The receiver cannot stall the result channel, so nothing ever backs up
// behind it.
module page_framebuffer_refresh_top #(
    parameter int COLUMNS = pfr_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfr_pkg::PAGES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pfr_pkg::op_t  op,
    input  wire logic [7:0]    x,
    input  wire logic [7:0]    y,
    input  wire logic          dot,
    output logic               strobe,
    output logic [7:0]         bus_byte,
    output logic               is_data,
    output logic               frame_done
);

    import pfr_pkg::*;

    localparam int DEPTH     = COLUMNS * PAGES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW        = $clog2(COLUMNS + CMD_SLOTS);
    localparam int PW        = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROWS      = 8 * PAGES;
    localparam int SLOT_LAST = COLUMNS + CMD_SLOTS - 1;

    // Sweep (reset and clear) state
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Refresh sequencer
    logic          refresh_reg;
    logic [PW-1:0] page_reg;
    logic [SW-1:0] slot_reg;

    // Request stage: registered at acceptance, aligned with read data
    logic          s1_tick_reg;
    logic          s1_draw_reg;
    logic          s1_data_reg;
    logic          s1_done_reg;
    logic [7:0]    s1_cmd_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [7:0]    s1_mask_reg;
    logic          s1_dot_reg;

    // Last write, forwarded over the read latency
    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [7:0]    lw_data_reg;

    logic          accept;
    logic          draw_ok;
    logic [15:0]   draw_prod;
    logic [15:0]   tick_prod;
    logic [SW-1:0] col;
    logic [AW-1:0] draw_addr;
    logic [AW-1:0] tick_addr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [7:0]    cur_byte;
    logic [7:0]    mod_byte;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          slot_wrap;
    logic          page_wrap;
    logic          tick_go;

    assign busy   = clr_active_reg;
    assign accept = start && !clr_active_reg;

    // Draw address: column-major, PAGES bytes per column
    assign draw_ok   = ({1'b0, x} < 9'(COLUMNS)) && ({1'b0, y} < 9'(ROWS));
    assign draw_prod = 16'(x) * 16'(PAGES) + 16'(y[7:3]);
    assign draw_addr = AW'(draw_prod);

    assign col       = slot_reg - SW'(CMD_SLOTS);
    assign tick_prod = 16'(col) * 16'(PAGES) + 16'(page_reg);
    assign tick_addr = AW'(tick_prod);

    assign raddr = (op == OP_DRAW) ? draw_addr : tick_addr;

    assign tick_go   = accept && (op == OP_TICK) && refresh_reg;
    assign slot_wrap = (slot_reg == SW'(SLOT_LAST));
    assign page_wrap = (page_reg == PW'(PAGES - 1));

    // Forward the byte written at the edge the read was taken
    assign cur_byte = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : rdata;
    assign mod_byte = s1_dot_reg ? (cur_byte | s1_mask_reg) : (cur_byte & ~s1_mask_reg);

    // Sweep owns the write port; no draw is in flight while it runs
    always_comb
    begin
        if (clr_active_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = 8'h00;
        end
        else
        begin
            we    = s1_draw_reg;
            waddr = s1_addr_reg;
            wdata = mod_byte;
        end
    end

    pfr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign strobe     = s1_tick_reg;
    assign is_data    = s1_data_reg;
    assign frame_done = s1_done_reg;
    assign bus_byte   = s1_data_reg ? cur_byte : s1_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            refresh_reg    <= 1'b0;
            page_reg       <= '0;
            slot_reg       <= '0;
            s1_tick_reg    <= 1'b0;
            s1_draw_reg    <= 1'b0;
            s1_data_reg    <= 1'b0;
            s1_done_reg    <= 1'b0;
            lw_valid_reg   <= 1'b0;
        end
        else
        begin
            // Sweep zeros through the store
            if (clr_active_reg)
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            else if (accept && (op == OP_CLEAR))
            begin
                clr_active_reg <= 1'b1;
                clr_addr_reg   <= '0;
            end

            // Refresh sequencer: restart on clear or refresh, advance on tick
            if (accept && ((op == OP_CLEAR) || (op == OP_REFRESH)))
            begin
                refresh_reg <= 1'b1;
                page_reg    <= '0;
                slot_reg    <= '0;
            end
            else if (tick_go)
            begin
                if (slot_wrap)
                begin
                    slot_reg <= '0;
                    if (page_wrap)
                    begin
                        page_reg    <= '0;
                        refresh_reg <= 1'b0;
                    end
                    else
                    begin
                        page_reg <= page_reg + PW'(1);
                    end
                end
                else
                begin
                    slot_reg <= slot_reg + SW'(1);
                end
            end

            s1_tick_reg <= tick_go;
            s1_draw_reg <= accept && (op == OP_DRAW) && draw_ok;
            s1_data_reg <= tick_go && (slot_reg >= SW'(CMD_SLOTS));
            s1_done_reg <= tick_go && slot_wrap && page_wrap;

            lw_valid_reg <= we;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= raddr;
        s1_mask_reg <= 8'(1) << y[2:0];
        s1_dot_reg  <= dot;
        case (slot_reg)
            SW'(0):  s1_cmd_reg <= CMD_PAGE_BASE + 8'(page_reg);
            SW'(1):  s1_cmd_reg <= CMD_COL_LO;
            SW'(2):  s1_cmd_reg <= CMD_COL_HI;
            default: s1_cmd_reg <= 8'h00;
        endcase
        lw_addr_reg <= waddr;
        lw_data_reg <= wdata;
    end

endmodule

`default_nettype wire

/* design/pfr_store.sv */
`default_nettype none

module pfr_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [DEPTH];

    // One write port, one registered read port; a read at the written
    // address returns the old byte.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

// Request/result checker for the page-addressed frame store.
//
// The request side follows the start/busy handshake: a request is taken at
// the rising edge where start is high and busy is low. Every taken request
// is applied to a local image of the frame store and the refresh engine.
// Each tick that the image says yields a bus byte pushes one expected beat.
// The result side cannot be stalled, so the result check simply pops the
// oldest expected beat whenever strobe is seen at a rising edge.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pfr_pkg::*;

    localparam int COLS        = pfr_pkg::COLUMNS_DEF;
    localparam int PGS         = pfr_pkg::PAGES_DEF;
    localparam int STORE_BYTES = COLS * PGS;
    localparam int PAGE_BEATS  = COLS + CMD_SLOTS;
    localparam int FRAME_BEATS = PGS * PAGE_BEATS;
    localparam int RANDOM_REQS = 24;
    localparam int LIVE_TICKS  = 32;
    localparam int MAX_GAP     = 12;
    // A clear stalls the request side for a whole store sweep; allow that
    // several times over before declaring the block hung.
    localparam int STALL_LIMIT = 8 * (STORE_BYTES + MAX_GAP);
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 50;

    // One beat on the panel bus.
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       frame_done;
    } bus_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    op_t         op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        dot;
    logic        strobe;
    logic [7:0]  bus_byte;
    logic        is_data;
    logic        frame_done;

    // Local image of the block: store contents and refresh engine position.
    logic [7:0]  pixel_img [0:STORE_BYTES-1];
    logic        img_refreshing;
    int          img_page;
    int          img_slot;

    bus_beat_t   beat_expect_q[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    logic        no_idle_run = 1'b0;

    page_framebuffer_refresh_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .x          (x),
        .y          (y),
        .dot        (dot),
        .strobe     (strobe),
        .bus_byte   (bus_byte),
        .is_data    (is_data),
        .frame_done (frame_done)
    );

    always #2 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Clear the image store, as reset and clear do.
    task automatic wipe_image();
        for (int i = 0; i < STORE_BYTES; i++)
            pixel_img[i] = 8'h00;
    endtask

    // Produce the next bus beat of the refresh sequence and advance the engine.
    function automatic bus_beat_t next_refresh_beat();
        bus_beat_t beat;
        beat = '0;
        if (img_slot == 0)
            beat.bus_byte = CMD_PAGE_BASE + 8'(img_page);
        else if (img_slot == 1)
            beat.bus_byte = CMD_COL_LO;
        else if (img_slot == 2)
            beat.bus_byte = CMD_COL_HI;
        else
        begin
            beat.bus_byte = pixel_img[(img_slot - CMD_SLOTS) * PGS + img_page];
            beat.is_data  = 1'b1;
        end
        img_slot++;
        if (img_slot >= PAGE_BEATS)
        begin
            img_slot = 0;
            img_page++;
            if (img_page >= PGS)
            begin
                beat.frame_done = 1'b1;
                img_page        = 0;
                img_refreshing  = 1'b0;
            end
        end
        return beat;
    endfunction

    // Apply one taken request to the image; queue the beat a tick yields.
    task automatic apply_request(input op_t o, input logic [7:0] xv,
                                 input logic [7:0] yv, input logic d);
        int idx;
        case (o)
            OP_DRAW:
            begin
                // Drop draws that fall off the panel.
                if (xv < COLS && yv < 8 * PGS)
                begin
                    idx = int'(xv) * PGS + int'(yv >> 3);
                    pixel_img[idx][yv[2:0]] = d;
                end
            end
            OP_CLEAR, OP_REFRESH:
            begin
                if (o == OP_CLEAR)
                    wipe_image();
                // Any refresh request restarts from page 0, slot 0.
                img_refreshing = 1'b1;
                img_page       = 0;
                img_slot       = 0;
            end
            default:
            begin
                if (img_refreshing)
                    beat_expect_q.push_back(next_refresh_beat());
            end
        endcase
    endtask

    // Send one request: idle a random number of cycles, hold start until the
    // block takes it, then fold it into the image. Called at a rising edge.
    task automatic send_request(input op_t o, input logic [7:0] xv,
                                input logic [7:0] yv, input logic d);
        int gap;
        gap = no_idle_run ? 0 : $urandom_range(0, MAX_GAP);
        // Switch now and then into and out of back-to-back bursts.
        if ($urandom_range(0, 31) == 0)
            no_idle_run = ~no_idle_run;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op    <= o;
        x     <= xv;
        y     <= yv;
        dot   <= d;
        do
            @(posedge clk);
        while (busy);
        apply_request(o, xv, yv, d);
    endtask

    // Send ticks with junk in the fields that a tick ignores.
    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_request(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Draw one random pixel; most land on the panel, the rest anywhere.
    task automatic send_random_draw();
        if ($urandom_range(0, 4) != 0)
            send_request(OP_DRAW, 8'($urandom_range(0, COLS - 1)),
                         8'($urandom_range(0, 8 * PGS - 1)), 1'($urandom));
        else
            send_request(OP_DRAW, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Ticks with nothing refreshing must stay silent.
    task automatic test_idle_tick();
        send_ticks(4);
    endtask

    // Hit the panel corners, the first rows and columns off the panel, and a
    // pixel darkened after lighting; then read the whole frame back.
    task automatic test_draw_edges();
        send_request(OP_DRAW, 8'd0,   8'd0,   1'b1);
        send_request(OP_DRAW, 8'd127, 8'd63,  1'b1);
        send_request(OP_DRAW, 8'd127, 8'd0,   1'b1);
        send_request(OP_DRAW, 8'd0,   8'd63,  1'b1);
        send_request(OP_DRAW, 8'd128, 8'd5,   1'b1);
        send_request(OP_DRAW, 8'd5,   8'd64,  1'b1);
        send_request(OP_DRAW, 8'd255, 8'd255, 1'b1);
        send_request(OP_DRAW, 8'd64,  8'd7,   1'b1);
        send_request(OP_DRAW, 8'd64,  8'd8,   1'b1);
        send_request(OP_DRAW, 8'd64,  8'd7,   1'b0);
        send_request(OP_DRAW, 8'd200, 8'd10,  1'b0);
        send_request(OP_REFRESH, 8'hFF, 8'hFF, 1'b1);
        send_ticks(FRAME_BEATS);
        // The sequence is over: further ticks yield nothing.
        send_ticks(2);
    endtask

    // Restart the sequence mid-frame with both refresh and clear.
    task automatic test_restart();
        send_request(OP_REFRESH, 8'h00, 8'h00, 1'b0);
        send_ticks(12);
        send_request(OP_REFRESH, 8'h55, 8'hAA, 1'b1);
        send_ticks(PAGE_BEATS + 9);
        send_request(OP_CLEAR, 8'hAA, 8'h55, 1'b0);
        send_ticks(4);
        for (int i = 0; i < 3; i++)
            send_random_draw();
        send_request(OP_REFRESH, 8'h00, 8'h00, 1'b0);
        send_ticks(8);
    endtask

    // Run the start of a frame with draws mixed in, so bytes not yet sent
    // pick up fresh pixels and bytes already sent do not.
    task automatic test_live_draw_frames();
        int ticks;
        send_request(OP_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
        ticks = 0;
        while (ticks < LIVE_TICKS)
        begin
            if ($urandom_range(0, 9) < 3)
                send_random_draw();
            else
            begin
                send_ticks(1);
                ticks++;
            end
        end
    endtask

    // Fill part of the store, clear it, and read back dark bytes.
    task automatic test_clear();
        for (int i = 0; i < 8; i++)
            send_random_draw();
        send_request(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
        send_ticks(16);
    endtask

    // Mostly ticks and draws, with the odd restart and clear.
    task automatic test_random_mix();
        int pick;
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 52)
                send_ticks(1);
            else if (pick < 92)
                send_random_draw();
            else if (pick < 98)
                send_request(OP_REFRESH, 8'($urandom), 8'($urandom),
                             1'($urandom));
            else
                send_request(OP_CLEAR, 8'($urandom), 8'($urandom),
                             1'($urandom));
        end
    endtask

    // Compare every result beat with the oldest expected beat.
    always @(posedge clk)
    begin : result_check
        bus_beat_t want;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (beat_expect_q.size() == 0)
                report_mismatch($sformatf("result %02h with nothing pending",
                                          bus_byte));
            else
            begin
                want = beat_expect_q.pop_front();
                if (bus_byte !== want.bus_byte)
                    report_mismatch($sformatf("bus_byte got %02h want %02h",
                                              bus_byte, want.bus_byte));
                if (is_data !== want.is_data)
                    report_mismatch($sformatf("is_data got %b want %b",
                                              is_data, want.is_data));
                if (frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done got %b want %b",
                                              frame_done, want.frame_done));
            end
        end
        else if (rst_n === 1'b1 && strobe !== 1'b0)
            report_mismatch("strobe is unknown");
    end

    // Count cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((start && !busy) || strobe)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", stall_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n = 1'b0;
        start = 1'b0;
        op    = OP_DRAW;
        x     = 8'h00;
        y     = 8'h00;
        dot   = 1'b0;
        wipe_image();
        img_refreshing = 1'b0;
        img_page       = 0;
        img_slot       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_tick();
        test_draw_edges();
        test_restart();
        test_live_draw_frames();
        test_clear();
        test_random_mix();

        // Drop start, let the last beats come out, then settle briefly.
        start <= 1'b0;
        while (beat_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (beat_expect_q.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      beat_expect_q.size()));

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
